@@ hdl/bit_packetizer_with_index_parity_macros.svh @@
// ----------------------------------------------------------------------------
// bit_packetizer_with_index_parity_macros
// Assertion macros for the bit packetizer. With SYNTHESIS defined they expand
// to nothing.
// ----------------------------------------------------------------------------
`ifndef BIT_PACKETIZER_WITH_INDEX_PARITY_MACROS_SVH
`define BIT_PACKETIZER_WITH_INDEX_PARITY_MACROS_SVH

`ifndef SYNTHESIS
`define BPIP_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("bpip: invariant violated");
`define BPIP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpip: implication violated");
`else
`define BPIP_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define BPIP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/bpip_pkg.sv @@
// ----------------------------------------------------------------------------
// bpip_pkg
// Shared types and fixed field widths of the bit packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package bpip_pkg;

    localparam int PAYLOAD_W = 32;
    localparam int INDEX_W   = 16;
    localparam int CFG_W     = 6;
    localparam logic [CFG_W-1:0] CFG_RESET = 6'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [INDEX_W-1:0]   seq_index;
        logic                 parity;
        logic                 end_marker;
        logic                 last;
    } t_out_item;

endpackage

`default_nettype wire

@@ hdl/bpip_front.sv @@
// ----------------------------------------------------------------------------
// bpip_front
// Input side: accepts byte transactions into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bit_packetizer_with_index_parity_macros.svh"

module bpip_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire bpip_pkg::t_in_item i_data,
    output logic                   o_q_valid,
    output bpip_pkg::t_in_item     o_q_item,
    input  wire logic              i_q_pop
);
    import bpip_pkg::*;

    t_in_item   r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;
    logic       pop;

    assign o_ready   = (r_count != 2'd2);
    assign o_q_valid = (r_count != 2'd0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign push      = i_valid && o_ready;
    assign pop       = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `BPIP_ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count != 2'd3)
    `BPIP_ASSERT_IMPLY(a_pop_nonempty, i_clk, i_rst_n, i_q_pop, r_count != 2'd0)
    `BPIP_ASSERT_IMPLY(a_ptr_track, i_clk, i_rst_n, r_count != 2'd1,
                       r_wr_ptr == r_rd_ptr)

endmodule

`default_nettype wire

@@ hdl/bpip_back.sv @@
// ----------------------------------------------------------------------------
// bpip_back
// Packing engine: folds queued bytes into the bit buffer, emits one packet per
// cycle to the output register while free, then a stream's partial and end packet.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bit_packetizer_with_index_parity_macros.svh"

module bpip_back #(
    parameter int INDEX_BITS       = 16,
    parameter int MAX_PAYLOAD_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [bpip_pkg::CFG_W-1:0]  i_width,
    input  wire logic                        i_clear,
    input  wire logic                        i_q_valid,
    input  wire bpip_pkg::t_in_item          i_q_item,
    output logic                             o_q_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output bpip_pkg::t_out_item              o_data
);
    import bpip_pkg::*;

    localparam int MW = MAX_PAYLOAD_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DATA = 4'b0010,
        S_PART = 4'b0100,
        S_END  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [MW-1:0]       r_buf, n_buf;
    logic [CFG_W-1:0]    r_fill, n_fill;
    logic [7:0]          r_bits, n_bits;
    logic [3:0]          r_rem, n_rem;
    logic                r_last, n_last;
    logic [INDEX_BITS-1:0] r_pkt, n_pkt;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [MW-1:0]       mask;
    logic [MW+7:0]       shifted;
    logic [MW-1:0]       merged;
    logic [CFG_W-1:0]    room;
    logic [7:0]          left_bits;
    logic [3:0]          left_rem;
    logic                fits;
    logic                left_done;
    logic                out_free;
    logic                emit;
    logic                take;
    t_out_item           n_out;
    logic [MW-1:0]       emit_pay;

    assign mask      = {MW{1'b1}} >> (CFG_W'(MW) - i_width);
    assign shifted   = (MW + 8)'(r_bits) << r_fill;
    assign merged    = r_buf | shifted[MW-1:0];
    assign room      = i_width - r_fill;
    assign fits      = {2'b00, r_rem} < room;
    // Only meaningful when the byte fills the packet, where room is at most eight.
    assign left_bits = r_bits >> room[3:0];
    assign left_rem  = r_rem - room[3:0];
    assign left_done = {2'b00, left_rem} < i_width;
    assign out_free  = !r_out_valid || i_ready;

    always_comb begin
        n_state  = r_state;
        n_buf    = r_buf;
        n_fill   = r_fill;
        n_bits   = r_bits;
        n_rem    = r_rem;
        n_last   = r_last;
        n_pkt    = r_pkt;
        emit     = 1'b0;
        take     = 1'b0;
        emit_pay = merged & mask;
        n_out.payload    = '0;
        n_out.seq_index  = INDEX_W'(r_pkt);
        n_out.parity     = 1'b0;
        n_out.end_marker = 1'b0;
        n_out.last       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                take = 1'b1;
            end
            S_DATA: begin
                if (fits) begin
                    n_buf  = merged;
                    n_fill = r_fill + CFG_W'(r_rem);
                    if (r_last) begin
                        n_state = (n_fill != '0) ? S_PART : S_END;
                    end else begin
                        take = 1'b1;
                    end
                end else begin
                    emit       = 1'b1;
                    n_out.last = left_done && !r_last;
                    if (out_free) begin
                        n_pkt = r_pkt + 1'b1;
                        if (left_done) begin
                            n_buf  = MW'(left_bits);
                            n_fill = CFG_W'(left_rem);
                            if (r_last) begin
                                n_state = (left_rem != 4'd0) ? S_PART : S_END;
                            end else begin
                                take = 1'b1;
                            end
                        end else begin
                            n_bits = left_bits;
                            n_rem  = left_rem;
                            n_buf  = '0;
                            n_fill = '0;
                        end
                    end
                end
            end
            S_PART: begin
                emit     = 1'b1;
                emit_pay = r_buf & mask;
                if (out_free) begin
                    n_pkt   = r_pkt + 1'b1;
                    n_buf   = '0;
                    n_fill  = '0;
                    n_state = S_END;
                end
            end
            S_END: begin
                emit             = 1'b1;
                emit_pay         = mask;
                n_out.seq_index  = INDEX_W'({INDEX_BITS{1'b1}});
                n_out.end_marker = 1'b1;
                n_out.last       = 1'b1;
                if (out_free) begin
                    n_pkt  = '0;
                    n_buf  = '0;
                    n_fill = '0;
                    take   = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out.payload = PAYLOAD_W'(emit_pay);
        if (r_state == S_END) begin
            n_out.parity = 1'b1;
        end else begin
            n_out.parity = (^emit_pay) ^ (^r_pkt);
        end

        o_q_pop = 1'b0;
        if (take) begin
            if (i_q_valid) begin
                o_q_pop = 1'b1;
                n_bits  = i_q_item.data_byte;
                n_rem   = 4'd8;
                n_last  = i_q_item.last_byte;
                n_state = S_DATA;
            end else begin
                n_state = S_IDLE;
            end
        end

        // A width change drops gathered bits; the user must make it only while idle (not enforced).
        if (i_clear) begin
            n_buf  = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_buf       <= '0;
            r_fill      <= '0;
            r_pkt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_buf   <= n_buf;
            r_fill  <= n_fill;
            r_pkt   <= n_pkt;
            if (emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        r_rem  <= n_rem;
        r_last <= n_last;
        if (emit && out_free) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    `BPIP_ASSERT_ALWAYS(a_fill_below_width, i_clk, i_rst_n, r_fill < i_width)
    `BPIP_ASSERT_IMPLY(a_partial_nonempty, i_clk, i_rst_n, r_state == S_PART,
                       r_fill != '0)
    `BPIP_ASSERT_IMPLY(a_end_closes, i_clk, i_rst_n, r_out_valid && r_out.end_marker,
                       r_out.last && r_out.parity)

endmodule

`default_nettype wire

@@ hdl/bit_packetizer_with_index_parity.sv @@
// Usage:
// Bytes arrive on i_valid/o_ready with i_data, bit 0 of each byte first, and
// last_byte set on the final byte of a stream. Packets leave on o_valid/i_ready
// with o_data: payload, packet number, even parity (one on the end packet), end
// marker, and a last flag on the final packet caused by each byte. An accepted
// byte passes the input queue and the engine's byte register before it reaches
// the output register. The packing engine produces one packet per cycle while
// the output register is free. A byte yields up to nine packets (a width of one
// with the stream end); a final byte that completes no packet is merged into the
// buffer before the closing packets. A two-entry input queue keeps bytes flowing
// while the engine works or the output waits. When the receiver stalls, the
// output register holds its packet and the engine and then the queue fill before
// o_ready drops. Reset empties the queue and the output, clears the bit buffer
// and the packet number, and sets the payload width to eight. A write of
// i_cfg_wdata on i_cfg_we is registered, drops gathered bits, keeps the packet
// number; widths of zero act as one and widths above the maximum as the maximum.
// ----------------------------------------------------------------------------
// bit_packetizer_with_index_parity
// Top level: width register, input queue and packing engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_packetizer_with_index_parity #(
    parameter int INDEX_BITS       = 16,
    parameter int MAX_PAYLOAD_BITS = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire bpip_pkg::t_in_item         i_data,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output bpip_pkg::t_out_item             o_data,
    input  wire logic                       i_cfg_we,
    input  wire logic [bpip_pkg::CFG_W-1:0] i_cfg_wdata
);
    import bpip_pkg::*;

    logic [CFG_W-1:0] r_cfg;
    logic [CFG_W-1:0] width;
    logic             q_valid;
    t_in_item         q_item;
    logic             q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            width = CFG_W'(1);
        end else if (r_cfg > CFG_W'(MAX_PAYLOAD_BITS)) begin
            width = CFG_W'(MAX_PAYLOAD_BITS);
        end else begin
            width = r_cfg;
        end
    end

    bpip_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_data    (i_data),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    bpip_back #(
        .INDEX_BITS       (INDEX_BITS),
        .MAX_PAYLOAD_BITS (MAX_PAYLOAD_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_width   (width),
        .i_clear   (i_cfg_we),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

endmodule

`default_nettype wire
